@@ rtl/core/gtth_pkg.sv @@
// ----------------------------------------------------------------------------
// gtth_pkg
// Shared types, constants and the arctangent table for the go-to-target
// heading setpoint pipeline.
// ----------------------------------------------------------------------------
package gtth_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANG_TAB_LEN   = 24;
  localparam int STG_IDX_W     = $clog2(ANG_TAB_LEN);
  localparam int POS_W         = 24;
  localparam int DIFF_W        = POS_W + 1;
  localparam int SQ_W          = 2 * POS_W;
  localparam int VEC_W         = 52;
  localparam int ANG_W         = 25;
  localparam int HDG_W         = 16;
  localparam int SPD_W         = 16;
  localparam int RAD_W         = 16;
  localparam int VEC_SHIFT     = 24;
  localparam int HEADING_LIMIT = 23040;
  localparam int QUARTER_TURN  = 90 * 32768;
  localparam int ROUND_BITS    = 8;
  localparam int PIPE_LAT      = CORDIC_STAGES + 4;

  localparam logic [POS_W-1:0] TARGET_X_RST     = '0;
  localparam logic [POS_W-1:0] TARGET_Y_RST     = '0;
  localparam logic [SPD_W-1:0] TARGET_SPEED_RST = SPD_W'(10240);
  localparam logic [RAD_W-1:0] ARRIVE_RAD_RST   = RAD_W'(512);

  typedef enum logic [1:0] {
    REG_TARGET_X     = 2'd0,
    REG_TARGET_Y     = 2'd1,
    REG_TARGET_SPEED = 2'd2,
    REG_ARRIVE_RAD   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic [SPD_W-1:0]        target_speed;
    logic [RAD_W-1:0]        arrive_radius;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic                     far;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [HDG_W-1:0]  heading;
  } dist_t;

  typedef struct packed {
    logic                    valid;
    logic                    far;
    logic signed [HDG_W-1:0] heading;
  } side_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  localparam logic [ANG_W-1:0] ATAN_TAB [ANG_TAB_LEN] = '{
    25'd1474560, 25'd870484, 25'd459940, 25'd233473, 25'd117189, 25'd58653,
    25'd29333,   25'd14667,  25'd7334,   25'd3667,   25'd1833,   25'd917,
    25'd458,     25'd229,    25'd115,    25'd57,     25'd29,     25'd14,
    25'd7,       25'd4,      25'd2,      25'd1,      25'd0,      25'd0
  };

  function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [STG_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    val = '0;
    if (int'(idx) < ANG_TAB_LEN) begin
      val = ATAN_TAB[idx];
    end
    return val;
  endfunction

endpackage

@@ rtl/core/gtth_cfg.sv @@
// ----------------------------------------------------------------------------
// gtth_cfg
// Configuration register file with an APB-style access port.
// ----------------------------------------------------------------------------
module gtth_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output gtth_pkg::cfg_t      cfg
);
  import gtth_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_TARGET_X:     cfg_nxt.target_x      = pwdata[POS_W-1:0];
        REG_TARGET_Y:     cfg_nxt.target_y      = pwdata[POS_W-1:0];
        REG_TARGET_SPEED: cfg_nxt.target_speed  = pwdata[SPD_W-1:0];
        REG_ARRIVE_RAD:   cfg_nxt.arrive_radius = pwdata[RAD_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_x      <= TARGET_X_RST;
      cfg_r.target_y      <= TARGET_Y_RST;
      cfg_r.target_speed  <= TARGET_SPEED_RST;
      cfg_r.arrive_radius <= ARRIVE_RAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET_X:     prdata = {{(32-POS_W){1'b0}}, cfg_r.target_x};
      REG_TARGET_Y:     prdata = {{(32-POS_W){1'b0}}, cfg_r.target_y};
      REG_TARGET_SPEED: prdata = {{(32-SPD_W){1'b0}}, cfg_r.target_speed};
      REG_ARRIVE_RAD:   prdata = {{(32-RAD_W){1'b0}}, cfg_r.arrive_radius};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/gtth_dist.sv @@
// ----------------------------------------------------------------------------
// gtth_dist
// Offset and squared-distance stages: forms the offset to the target, squares
// both components and the arrival radius, and compares the sum.
// ----------------------------------------------------------------------------
module gtth_dist (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  gtth_pkg::cfg_t                        cfg,
  input  logic                                  in_valid,
  input  logic signed [gtth_pkg::POS_W-1:0]     pos_x,
  input  logic signed [gtth_pkg::POS_W-1:0]     pos_y,
  input  logic signed [gtth_pkg::HDG_W-1:0]     heading,
  output gtth_pkg::dist_t                       dist_info
);
  import gtth_pkg::*;

  logic                     a_valid_r;
  logic signed [DIFF_W-1:0] a_dx_r;
  logic signed [DIFF_W-1:0] a_dy_r;
  logic signed [HDG_W-1:0]  a_hdg_r;

  logic                     b_valid_r;
  logic signed [DIFF_W-1:0] b_dx_r;
  logic signed [DIFF_W-1:0] b_dy_r;
  logic signed [HDG_W-1:0]  b_hdg_r;
  logic [SQ_W-1:0]          b_dxsq_r;
  logic [SQ_W-1:0]          b_dysq_r;
  logic [2*RAD_W-1:0]       b_rsq_r;

  logic signed [DIFF_W-1:0]   dx_nxt;
  logic signed [DIFF_W-1:0]   dy_nxt;
  logic signed [2*DIFF_W-1:0] dxsq_full;
  logic signed [2*DIFF_W-1:0] dysq_full;
  logic [SQ_W:0]              d2_sum;

  assign dx_nxt    = DIFF_W'(cfg.target_x) - DIFF_W'(pos_x);
  assign dy_nxt    = DIFF_W'(cfg.target_y) - DIFF_W'(pos_y);
  assign dxsq_full = a_dx_r * a_dx_r;
  assign dysq_full = a_dy_r * a_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_dx_r   <= dx_nxt;
    a_dy_r   <= dy_nxt;
    a_hdg_r  <= heading;
    b_dx_r   <= a_dx_r;
    b_dy_r   <= a_dy_r;
    b_hdg_r  <= a_hdg_r;
    b_dxsq_r <= dxsq_full[SQ_W-1:0];
    b_dysq_r <= dysq_full[SQ_W-1:0];
    b_rsq_r  <= cfg.arrive_radius * cfg.arrive_radius;
  end

  assign d2_sum = {1'b0, b_dxsq_r} + {1'b0, b_dysq_r};

  assign dist_info.valid   = b_valid_r;
  assign dist_info.far     = d2_sum > (SQ_W + 1)'(b_rsq_r);
  assign dist_info.dx      = b_dx_r;
  assign dist_info.dy      = b_dy_r;
  assign dist_info.heading = b_hdg_r;

endmodule

@@ rtl/core/gtth_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// gtth_cordic_stage
// One registered vectoring iteration of the CORDIC chain.
// ----------------------------------------------------------------------------
module gtth_cordic_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [gtth_pkg::STG_IDX_W-1:0]    idx,
  input  gtth_pkg::vec_t                    vec_in,
  input  gtth_pkg::side_t                   side_in,
  output gtth_pkg::vec_t                    vec_out,
  output gtth_pkg::side_t                   side_out
);
  import gtth_pkg::*;

  vec_t                    vec_r;
  vec_t                    vec_nxt;
  side_t                   side_r;
  logic signed [VEC_W-1:0] x_in;
  logic signed [VEC_W-1:0] y_in;
  logic signed [ANG_W-1:0] z_in;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  logic signed [ANG_W-1:0] ang;

  always_comb begin
    x_in = vec_in.x;
    y_in = vec_in.y;
    z_in = vec_in.z;
    xs   = x_in >>> idx;
    ys   = y_in >>> idx;
    ang  = atan_lookup(idx);
    if (!y_in[VEC_W-1]) begin
      vec_nxt.x = x_in + ys;
      vec_nxt.y = y_in - xs;
      vec_nxt.z = z_in + ang;
    end else begin
      vec_nxt.x = x_in - ys;
      vec_nxt.y = y_in + xs;
      vec_nxt.z = z_in - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r.far     <= side_in.far;
    side_r.heading <= side_in.heading;
    vec_r          <= vec_nxt;
  end

  assign vec_out  = vec_r;
  assign side_out = side_r;

endmodule

@@ rtl/core/gtth_cordic.sv @@
// ----------------------------------------------------------------------------
// gtth_cordic
// Quadrant pre-rotation stage followed by the chain of CORDIC iterations.
// ----------------------------------------------------------------------------
module gtth_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  gtth_pkg::dist_t   dist_info,
  output gtth_pkg::vec_t    vec_out,
  output gtth_pkg::side_t   side_out
);
  import gtth_pkg::*;

  vec_t                    pre_nxt;
  vec_t                    chain_vec  [CORDIC_STAGES+1];
  side_t                   chain_side [CORDIC_STAGES+1];
  vec_t                    pre_r;
  side_t                   pre_side_r;
  logic signed [VEC_W-1:0] sx;
  logic signed [VEC_W-1:0] sy;

  always_comb begin
    sx = VEC_W'(dist_info.dx) <<< VEC_SHIFT;
    sy = VEC_W'(dist_info.dy) <<< VEC_SHIFT;
    pre_nxt.x = sx;
    pre_nxt.y = sy;
    pre_nxt.z = '0;
    if (sx[VEC_W-1]) begin
      if (!sy[VEC_W-1]) begin
        pre_nxt.x = sy;
        pre_nxt.y = -sx;
        pre_nxt.z = ANG_W'(QUARTER_TURN);
      end else begin
        pre_nxt.x = -sy;
        pre_nxt.y = sx;
        pre_nxt.z = -ANG_W'(QUARTER_TURN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_side_r.valid <= 1'b0;
    end else begin
      pre_side_r.valid <= dist_info.valid;
    end
  end

  always_ff @(posedge clk) begin
    pre_side_r.far     <= dist_info.far;
    pre_side_r.heading <= dist_info.heading;
    pre_r              <= pre_nxt;
  end

  assign chain_vec[0]  = pre_r;
  assign chain_side[0] = pre_side_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    gtth_cordic_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (STG_IDX_W'(g)),
      .vec_in   (chain_vec[g]),
      .side_in  (chain_side[g]),
      .vec_out  (chain_vec[g+1]),
      .side_out (chain_side[g+1])
    );
  end

  assign vec_out  = chain_vec[CORDIC_STAGES];
  assign side_out = chain_side[CORDIC_STAGES];

endmodule

@@ rtl/core/go_to_target_heading_setpoint.sv @@
// ----------------------------------------------------------------------------
// go_to_target_heading_setpoint
// Commands speed and heading toward a configured target point, or zero speed
// and the present heading once inside the arrival radius.
//
//   channel  ports                     flow control
//   input    start, busy, in_*         item taken when start and not busy
//   result   out_valid, out_*          one-cycle strobe, no back pressure
//   config   psel, penable, pwrite,    APB write in setup and access cycles,
//            paddr, pwdata, prdata,    pready always high
//            pready
//
// An item can be accepted in every cycle while busy is low. Its result
// strobes after the pipeline registers: offset, squares, compare and
// pre-rotation, one register per CORDIC iteration, then rounding.
// Reset clears the valid bits of every stage and holds busy high.
// Nothing stalls, since the receiver takes every result.
// ----------------------------------------------------------------------------
module go_to_target_heading_setpoint (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [gtth_pkg::POS_W-1:0]   in_position_x,
  input  logic signed [gtth_pkg::POS_W-1:0]   in_position_y,
  input  logic signed [gtth_pkg::HDG_W-1:0]   in_heading_now,
  output logic                                out_valid,
  output logic [gtth_pkg::SPD_W-1:0]          out_speed_setpoint,
  output logic signed [gtth_pkg::HDG_W-1:0]   out_heading_setpoint,
  output logic                                out_at_target,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import gtth_pkg::*;

  cfg_t                      cfg;
  dist_t                     dist_info;
  vec_t                      cvec;
  side_t                     cside;
  logic                      accept;
  logic signed [ANG_W:0]     z_sum;
  logic signed [ANG_W:0]     z_rnd;
  logic signed [HDG_W-1:0]   hdg_target;

  logic                      out_valid_r;
  logic [SPD_W-1:0]          speed_r;
  logic [SPD_W-1:0]          speed_nxt;
  logic signed [HDG_W-1:0]   heading_r;
  logic signed [HDG_W-1:0]   heading_nxt;
  logic                      at_target_r;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  gtth_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gtth_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (accept),
    .pos_x     (in_position_x),
    .pos_y     (in_position_y),
    .heading   (in_heading_now),
    .dist_info (dist_info)
  );

  gtth_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .dist_info (dist_info),
    .vec_out   (cvec),
    .side_out  (cside)
  );

  always_comb begin
    z_sum = (ANG_W + 1)'(cvec.z) + (ANG_W + 1)'(1 << (ROUND_BITS - 1));
    z_rnd = z_sum >>> ROUND_BITS;
    if (z_rnd > (ANG_W + 1)'(HEADING_LIMIT)) begin
      hdg_target = HDG_W'(HEADING_LIMIT);
    end else if (z_rnd < -(ANG_W + 1)'(HEADING_LIMIT)) begin
      hdg_target = -HDG_W'(HEADING_LIMIT);
    end else begin
      hdg_target = z_rnd[HDG_W-1:0];
    end
    speed_nxt   = cside.far ? cfg.target_speed : '0;
    heading_nxt = cside.far ? hdg_target : cside.heading;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cside.valid;
    end
  end

  always_ff @(posedge clk) begin
    speed_r     <= speed_nxt;
    heading_r   <= heading_nxt;
    at_target_r <= !cside.far;
  end

  assign out_valid            = out_valid_r;
  assign out_speed_setpoint   = speed_r;
  assign out_heading_setpoint = heading_r;
  assign out_at_target        = at_target_r;

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(PIPE_LAT) out_valid)
    else $error("accepted item produced no result strobe at the pipeline latency");

  a_arrived_stop : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_target |-> out_speed_setpoint == '0)
    else $error("arrived item commands a nonzero speed");

  a_heading_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_at_target |->
      out_heading_setpoint <= HDG_W'(HEADING_LIMIT) &&
      out_heading_setpoint >= -HDG_W'(HEADING_LIMIT))
    else $error("target heading outside the saturation limits");

  a_reset_quiet : assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result strobe directly after reset");
`endif

endmodule

@@ tb/go_to_target_heading_setpoint_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_target_heading_setpoint_tb
// Drives position and heading items into the heading setpoint block, predicts
// each commanded speed, heading and arrival flag from the target registers,
// and checks every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module go_to_target_heading_setpoint_tb;
  import gtth_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 60;

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  localparam longint ARCTAN_DEG [24] = '{
    1474560, 870484, 459940, 233473, 117189, 58653, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  typedef struct {
    logic [SPD_W-1:0]        speed;
    logic signed [HDG_W-1:0] heading;
    logic                    at_target;
  } setpoint_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [POS_W-1:0]  in_position_x;
  logic signed [POS_W-1:0]  in_position_y;
  logic signed [HDG_W-1:0]  in_heading_now;
  logic                     out_valid;
  logic [SPD_W-1:0]         out_speed_setpoint;
  logic signed [HDG_W-1:0]  out_heading_setpoint;
  logic                     out_at_target;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [3:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  logic signed [POS_W-1:0]  cur_target_x;
  logic signed [POS_W-1:0]  cur_target_y;
  logic [SPD_W-1:0]         cur_target_speed;
  logic [RAD_W-1:0]         cur_arrive_radius;

  setpoint_t pending_setpoints[$];
  int        fail_count;
  int        mismatch_count;
  int        idle_cycles;
  bit        idle_on;

  go_to_target_heading_setpoint dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_position_x        (in_position_x),
    .in_position_y        (in_position_y),
    .in_heading_now       (in_heading_now),
    .out_valid            (out_valid),
    .out_speed_setpoint   (out_speed_setpoint),
    .out_heading_setpoint (out_heading_setpoint),
    .out_at_target        (out_at_target),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [HDG_W-1:0] bearing_to_target(input longint dx,
                                                                input longint dy);
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    int     i;
    x = dx * 64'sd16777216;
    y = dy * 64'sd16777216;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x;
        x = y;
        y = -t;
        z = QUARTER_TURN;
      end else begin
        t = x;
        x = -y;
        y = t;
        z = -QUARTER_TURN;
      end
    end
    for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_DEG[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_DEG[i];
      end
    end
    z = (z + 128) >>> 8;
    if (z > HEADING_LIMIT) z = HEADING_LIMIT;
    if (z < -HEADING_LIMIT) z = -HEADING_LIMIT;
    return HDG_W'(z);
  endfunction

  function automatic setpoint_t predict_setpoint(input logic signed [POS_W-1:0] px,
                                                 input logic signed [POS_W-1:0] py,
                                                 input logic signed [HDG_W-1:0] hd);
    setpoint_t sp;
    longint    dx;
    longint    dy;
    longint    d2;
    longint    r2;
    dx = longint'(cur_target_x) - longint'(px);
    dy = longint'(cur_target_y) - longint'(py);
    d2 = dx * dx + dy * dy;
    r2 = longint'(cur_arrive_radius) * longint'(cur_arrive_radius);
    if (d2 > r2) begin
      sp.speed     = cur_target_speed;
      sp.heading   = bearing_to_target(dx, dy);
      sp.at_target = 1'b0;
    end else begin
      sp.speed     = '0;
      sp.heading   = hd;
      sp.at_target = 1'b1;
    end
    return sp;
  endfunction

  always @(posedge clk) begin : check_results
    setpoint_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_setpoints.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with no item pending: speed %0d heading %0d at %0b",
                   $realtime, out_speed_setpoint, out_heading_setpoint, out_at_target);
        end
      end else begin
        want = pending_setpoints.pop_front();
        if (out_speed_setpoint !== want.speed || out_heading_setpoint !== want.heading ||
            out_at_target !== want.at_target) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch: speed %0d/%0d heading %0d/%0d at %0b/%0b (exp/got)",
                     $realtime, want.speed, out_speed_setpoint, want.heading,
                     out_heading_setpoint, want.at_target, out_at_target);
          end
        end
      end
    end
    if (rst_n && start && !busy) begin
      pending_setpoints.push_back(predict_setpoint(in_position_x, in_position_y,
                                                   in_heading_now));
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_position(input logic signed [POS_W-1:0] px,
                               input logic signed [POS_W-1:0] py,
                               input logic signed [HDG_W-1:0] hd);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 12)) : 0;
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          = 1'b1;
    in_position_x  = px;
    in_position_y  = py;
    in_heading_now = hd;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_setpoints.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TARGET_X:     cur_target_x = data[POS_W-1:0];
      REG_TARGET_Y:     cur_target_y = data[POS_W-1:0];
      REG_TARGET_SPEED: cur_target_speed = data[SPD_W-1:0];
      REG_ARRIVE_RAD:   cur_arrive_radius = data[RAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // The upper data bits are random so that the register truncation is exercised.
  task automatic set_target(input logic signed [POS_W-1:0] tx,
                            input logic signed [POS_W-1:0] ty,
                            input logic [SPD_W-1:0] spd,
                            input logic [RAD_W-1:0] rad);
    wait_drained();
    write_reg(REG_TARGET_X, {8'($urandom), tx});
    write_reg(REG_TARGET_Y, {8'($urandom), ty});
    write_reg(REG_TARGET_SPEED, {16'($urandom), spd});
    write_reg(REG_ARRIVE_RAD, {16'($urandom), rad});
  endtask

  function automatic logic signed [POS_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      3: return POS_W'(int'($urandom_range(0, 4096)) - 2048);
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] pick_radius();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 16'hFFFF;
      2: return RAD_W'($urandom_range(1, 600));
      default: return RAD_W'($urandom);
    endcase
  endfunction

  function automatic logic [SPD_W-1:0] pick_speed();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'hFFFF;
      default: return SPD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [HDG_W-1:0] pick_heading();
    if ($urandom_range(0, 3) == 0) return HDG_W'($urandom);
    return HDG_W'(int'($urandom_range(0, 2 * HEADING_LIMIT)) - HEADING_LIMIT);
  endfunction

  task automatic send_random_position();
    int dx;
    int dy;
    int span;
    int sgn;
    dx = 0;
    dy = 0;
    span = int'(cur_arrive_radius) + 4;
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        send_position(POS_W'($urandom), POS_W'($urandom), pick_heading());
        return;
      end
      4, 5, 6: begin
        dx = int'($urandom_range(0, 2 * span)) - span;
        dy = int'($urandom_range(0, 2 * span)) - span;
      end
      7: begin
        if ($urandom_range(0, 1)) begin
          dx = sgn * (int'(cur_arrive_radius) + int'($urandom_range(0, 1)));
        end else begin
          dy = sgn * (int'(cur_arrive_radius) + int'($urandom_range(0, 1)));
        end
      end
      8: begin
        if ($urandom_range(0, 1)) begin
          dx = sgn * int'($urandom_range(1, 2000000));
        end else begin
          dy = sgn * int'($urandom_range(1, 2000000));
        end
      end
      default: begin
        send_position($urandom_range(0, 1) ? POS_MAX : POS_MIN,
                      $urandom_range(0, 1) ? POS_MAX : POS_MIN, pick_heading());
        return;
      end
    endcase
    send_position(POS_W'(int'(cur_target_x) - dx), POS_W'(int'(cur_target_y) - dy),
                  pick_heading());
  endtask

  task automatic test_reset_config();
    idle_on = 1'b1;
    send_position(24'sd0, 24'sd0, 16'sd100);
    send_position(24'sd512, 24'sd0, -16'sd5);
    send_position(-24'sd513, 24'sd0, 16'sd7);
    send_position(24'sd0, 24'sd0, 16'sh7FFF);
    send_position(24'sd0, 24'sd0, 16'sh8000);
  endtask

  task automatic test_arrival_edges();
    set_target(24'sd1000, -24'sd1000, 16'hFFFF, 16'd0);
    send_position(24'sd1000, -24'sd1000, 16'sd300);
    send_position(24'sd1001, -24'sd1000, 16'sd300);
    set_target(24'sd1000, -24'sd1000, 16'd0, 16'hFFFF);
    send_position(-24'sd64535, -24'sd1000, -16'sd300);
    send_position(-24'sd64535, -24'sd999, -16'sd300);
    send_position(24'sd1000, 24'sd64535, 16'sd23040);
    send_position(24'sd1000, 24'sd64536, -16'sd23040);
  endtask

  task automatic test_bearing_quadrants();
    set_target(24'sd0, 24'sd0, 16'd1234, 16'd0);
    send_position(-24'sd256, 24'sd0, 16'sd0);
    send_position(24'sd0, -24'sd256, 16'sd0);
    send_position(24'sd256, 24'sd0, 16'sd0);
    send_position(24'sd0, 24'sd256, 16'sd0);
    send_position(-24'sd300, -24'sd300, 16'sd0);
    send_position(24'sd300, -24'sd300, 16'sd0);
    send_position(24'sd300, 24'sd300, 16'sd0);
    send_position(-24'sd300, 24'sd300, 16'sd0);
    send_position(24'sd5, -24'sd70000, 16'sd0);
    set_target(POS_MAX, POS_MAX, 16'd1234, 16'hFFFF);
    send_position(POS_MIN, POS_MIN, 16'sd0);
    send_position(POS_MAX, POS_MIN, 16'sd0);
    set_target(POS_MIN, POS_MIN, 16'd4321, 16'd0);
    send_position(POS_MAX, POS_MAX, 16'sd0);
    send_position(POS_MIN, POS_MAX, 16'sd0);
  endtask

  task automatic test_random_phases();
    int p;
    int n;
    for (p = 0; p < NUM_PHASES; p++) begin
      set_target(pick_coord(), pick_coord(), pick_speed(), pick_radius());
      idle_on = (p % 4) != 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ((p % 2) == 1 && n == PHASE_ITEMS / 2) wait_drained();
        send_random_position();
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_position_x  = '0;
    in_position_y  = '0;
    in_heading_now = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    fail_count     = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    idle_on        = 1'b1;
    cur_target_x      = TARGET_X_RST;
    cur_target_y      = TARGET_Y_RST;
    cur_target_speed  = TARGET_SPEED_RST;
    cur_arrive_radius = ARRIVE_RAD_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_config();
    test_arrival_edges();
    test_bearing_quadrants();
    test_random_phases();

    wait_drained();
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (pending_setpoints.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/gtth_pkg.sv
rtl/core/gtth_cfg.sv
rtl/core/gtth_dist.sv
rtl/core/gtth_cordic_stage.sv
rtl/core/gtth_cordic.sv
rtl/core/go_to_target_heading_setpoint.sv
tb/go_to_target_heading_setpoint_tb.sv
